FILE: rtl/aabb_volume_table_locate_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef AABB_VOLUME_TABLE_LOCATE_DEFINES_SVH
`define AABB_VOLUME_TABLE_LOCATE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AVTL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("avtl assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AVTL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("avtl assertion failed");

`endif

FILE: rtl/avtl_pkg.sv
`default_nettype none

package avtl_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W    = 32;
    localparam int WORLD_W = 4;
    localparam int COORD_W = 64;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ACT_CREATE  = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_LOCATE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ZEROID   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]                action;
        logic [WORLD_W-1:0]        world_tag;
        logic [ID_W-1:0]           volume_id;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_req;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] result_id;
    } t_rsp;

    // one table entry, valid bit kept apart
    typedef struct packed {
        logic [WORLD_W-1:0]        world;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } t_entry;

    typedef struct packed {
        logic             en_valid;
        logic             en_data;
        logic             valid_bit;
        logic [IDX_W-1:0] addr;
    } t_wr_ctl;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_issue;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             hit;
        logic             free;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  id;
    } t_match;

endpackage

`default_nettype wire

FILE: rtl/avtl_store.sv
`default_nettype none

module avtl_store import avtl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire t_wr_ctl          i_wr,
    input  wire t_entry           i_wr_data,
    output logic                  o_rd_valid,
    output t_entry                o_rd_data
);

    logic   r_valid_mem [SLOTS];
    t_entry r_data_mem  [SLOTS];
    logic   r_rd_valid;
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en_valid) begin
            r_valid_mem[i_wr.addr] <= i_wr.valid_bit;
        end
        r_rd_valid <= r_valid_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en_data) begin
            r_data_mem[i_wr.addr] <= i_wr_data;
        end
        r_rd_data <= r_data_mem[i_rd_addr];
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/avtl_match.sv
`default_nettype none

module avtl_match import avtl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_issue i_issue,
    input  wire t_req   i_req,
    input  wire logic   i_rd_valid,
    input  wire t_entry i_rd_data,
    output t_match      o_match
);

    t_issue r_tag;
    t_match r_match;
    t_match n_match;

    logic w_key;
    logic w_id_eq;
    logic w_inside;

    // tag is registered alongside the table read, the flags get a register of their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_match <= '0;
        end else begin
            r_tag   <= i_issue;
            r_match <= n_match;
        end
    end

    always_comb begin
        w_key    = i_rd_valid && (i_rd_data.world == i_req.world_tag);
        w_id_eq  = (i_rd_data.id == i_req.volume_id);
        // inclusive on every bound; inverted boxes fail naturally
        w_inside = ($signed(i_rd_data.lo_x) <= $signed(i_req.point_x)) &&
                   ($signed(i_req.point_x) <= $signed(i_rd_data.hi_x)) &&
                   ($signed(i_rd_data.lo_y) <= $signed(i_req.point_y)) &&
                   ($signed(i_req.point_y) <= $signed(i_rd_data.hi_y)) &&
                   ($signed(i_rd_data.lo_z) <= $signed(i_req.point_z)) &&
                   ($signed(i_req.point_z) <= $signed(i_rd_data.hi_z));

        n_match.vld  = r_tag.vld;
        n_match.last = r_tag.last;
        n_match.idx  = r_tag.idx;
        n_match.free = !i_rd_valid;
        n_match.hit  = w_key && ((i_req.action == ACT_LOCATE) ? w_inside : w_id_eq);
        n_match.id   = i_rd_data.id;
    end

    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: rtl/avtl_seq.sv
`default_nettype none

module avtl_seq import avtl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_req             i_req,
    input  wire t_match           i_match,
    output logic                  o_busy,
    output logic                  o_done,
    output t_rsp                  o_rsp,
    output t_req                  o_req,
    output t_issue                o_issue,
    output logic [IDX_W-1:0]      o_rd_addr,
    output t_wr_ctl               o_wr,
    output t_entry                o_wr_data
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_addr;
    t_req             r_req;
    logic [ID_W-1:0]  r_next_id;
    logic [ID_W-1:0]  n_next_id;
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [ID_W-1:0]  r_hit_id;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_done;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic            w_accept;
    logic            w_last;
    logic [ID_W-1:0] w_base;
    logic            w_id_zero;
    logic            w_create_ok;
    logic            w_destroy_ok;
    logic [ID_W-1:0] w_new_id;

    assign w_accept = (r_state == S_IDLE) && i_start;
    assign w_last   = (r_addr == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_match.vld && i_match.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outcome of the finished scan
    always_comb begin
        w_base       = (r_next_id == '0) ? ID_W'(1) : r_next_id;
        w_id_zero    = (r_req.volume_id == '0);
        w_create_ok  = r_free_found && (w_id_zero || !r_found);
        w_destroy_ok = !w_id_zero && r_found;
        w_new_id     = w_id_zero ? w_base : r_req.volume_id;

        n_next_id = w_base;
        if (w_create_ok) begin
            if (w_id_zero) begin
                n_next_id = w_base + ID_W'(1);
            end else if (r_req.volume_id >= w_base) begin
                n_next_id = r_req.volume_id + ID_W'(1);
            end
        end

        n_rsp.status    = ST_OK;
        n_rsp.result_id = '0;
        priority if (r_req.action == ACT_CREATE) begin
            if (!w_id_zero && r_found) begin
                n_rsp.status = ST_DUP;
            end else if (!r_free_found) begin
                n_rsp.status = ST_FULL;
            end else begin
                n_rsp.result_id = w_new_id;
            end
        end else if (r_req.action == ACT_DESTROY) begin
            if (w_id_zero) begin
                n_rsp.status = ST_ZEROID;
            end else if (!r_found) begin
                n_rsp.status = ST_NOTFOUND;
            end
        end else if (r_req.action == ACT_LOCATE) begin
            if (r_found) begin
                n_rsp.result_id = r_hit_id;
            end else begin
                n_rsp.status = ST_NOTFOUND;
            end
        end else begin
            n_rsp.status = ST_OK;
        end
    end

    // outputs
    always_comb begin
        o_busy    = (r_state != S_IDLE);
        o_issue.vld  = (r_state == S_SCAN);
        o_issue.last = w_last;
        o_issue.idx  = r_addr;
        o_rd_addr = r_addr;

        o_wr.en_valid  = 1'b0;
        o_wr.en_data   = 1'b0;
        o_wr.valid_bit = 1'b0;
        o_wr.addr      = r_addr;
        if (r_state == S_CLEAR) begin
            o_wr.en_valid = 1'b1;
        end else if (r_state == S_DONE) begin
            if ((r_req.action == ACT_CREATE) && w_create_ok) begin
                o_wr.en_valid  = 1'b1;
                o_wr.en_data   = 1'b1;
                o_wr.valid_bit = 1'b1;
                o_wr.addr      = r_free_idx;
            end else if ((r_req.action == ACT_DESTROY) && w_destroy_ok) begin
                o_wr.en_valid = 1'b1;
                o_wr.addr     = r_hit_idx;
            end
        end

        o_wr_data.world = r_req.world_tag;
        o_wr_data.id    = w_new_id;
        o_wr_data.lo_x  = r_req.min_x;
        o_wr_data.lo_y  = r_req.min_y;
        o_wr_data.lo_z  = r_req.min_z;
        o_wr_data.hi_x  = r_req.max_x;
        o_wr_data.hi_y  = r_req.max_y;
        o_wr_data.hi_z  = r_req.max_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_next_id    <= ID_W'(1);
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);

            if ((r_state == S_CLEAR) || (r_state == S_SCAN)) begin
                r_addr <= w_last ? '0 : r_addr + IDX_W'(1);
            end

            if (w_accept) begin
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_match.vld) begin
                // keep the first hit and the first free slot in slot order
                if (i_match.hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (i_match.free && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end

            if ((r_state == S_DONE) && (r_req.action == ACT_CREATE)) begin
                r_next_id <= n_next_id;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (i_match.vld && i_match.hit && !r_found) begin
            r_hit_idx <= i_match.idx;
            r_hit_id  <= i_match.id;
        end
        if (i_match.vld && i_match.free && !r_free_found) begin
            r_free_idx <= i_match.idx;
        end
        if (r_state == S_DONE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;
    assign o_req  = r_req;

endmodule

`default_nettype wire

FILE: rtl/aabb_volume_table_locate.sv
// Each request scans the whole table through the single read port, one slot per cycle, then
// drains the read and compare registers, writes back and raises o_done. A new request is
// taken only once busy has dropped, so requests do not overlap.
// Reset: synchronous, active low; afterwards a clearing pass over every slot's valid bit
// keeps busy high. o_done is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none
`include "aabb_volume_table_locate_defines.svh"

module aabb_volume_table_locate import avtl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);

    // Flow per request:
    //   SCAN  - sequencer walks the slot address 0..SLOTS-1, one read per cycle
    //   match - compare unit registers per-slot flags behind the registered table read
    //   WAIT  - drain the last slot out of the read and compare stages
    //   DONE  - pick status/id, single write back (create or destroy), counter update
    // The valid bits live in their own array so destroy and the clearing pass touch one bit.

    t_req    w_req;
    t_issue  w_issue;
    t_match  w_match;
    t_wr_ctl w_wr;
    t_entry  w_wr_data;
    t_entry  w_rd_data;
    logic    w_rd_valid;
    logic [IDX_W-1:0] w_rd_addr;

    avtl_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_match   (w_match),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_req     (w_req),
        .o_issue   (w_issue),
        .o_rd_addr (w_rd_addr),
        .o_wr      (w_wr),
        .o_wr_data (w_wr_data)
    );

    // table storage: registered read, one write port
    avtl_store u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (w_rd_addr),
        .i_wr       (w_wr),
        .i_wr_data  (w_wr_data),
        .o_rd_valid (w_rd_valid),
        .o_rd_data  (w_rd_data)
    );

    // shared compare unit: world/id match or point containment, one slot a cycle
    avtl_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (w_issue),
        .i_req      (w_req),
        .i_rd_valid (w_rd_valid),
        .i_rd_data  (w_rd_data),
        .o_match    (w_match)
    );

    // result strobe never overlaps work in flight
    `AVTL_ASSERT_IMP(a_done_not_busy, o_done, !busy)
    // an accepted transfer starts work on the next cycle
    `AVTL_ASSERT_NXT(a_start_goes_busy, start && !busy, busy)
    // the table is never written while the scan is reading it
    `AVTL_ASSERT_IMP(a_no_write_in_scan, w_issue.vld, !w_wr.en_valid && !w_wr.en_data)
    // only defined status codes are reported
    `AVTL_ASSERT_IMP(a_status_legal, o_done, o_rsp.status <= ST_ZEROID)

endmodule

`default_nettype wire

FILE: test/aabb_table_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the box table, keeps its own
// copy of the table, and compares every result with the oldest prediction.
module aabb_table_checker import avtl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_done,
    input  t_rsp i_rsp,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_checked
);

    logic            box_valid [SLOTS];
    t_entry          box_store [SLOTS];
    logic [ID_W-1:0] next_auto_id;
    t_rsp            pending_rsp [$];
    t_rsp            want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
        o_mismatches++;
    endtask

    // first valid slot holding this id in this world, -1 when none
    function automatic int find_box(logic [WORLD_W-1:0] world, logic [ID_W-1:0] id);
        int slot;
        for (slot = 0; slot < SLOTS; slot++) begin
            if (box_valid[slot] && box_store[slot].world == world && box_store[slot].id == id)
                return slot;
        end
        return -1;
    endfunction

    function automatic t_rsp predict_table_op(t_req r);
        t_rsp            rsp;
        int              slot;
        logic [ID_W-1:0] id;
        rsp.status    = ST_OK;
        rsp.result_id = '0;
        id            = r.volume_id;
        case (r.action)
            ACT_CREATE: begin
                if (next_auto_id == '0)
                    next_auto_id = 1;
                if (id != '0 && find_box(r.world_tag, id) >= 0) begin
                    rsp.status = ST_DUP;
                end else begin
                    slot = 0;
                    while (slot < SLOTS && box_valid[slot])
                        slot++;
                    if (slot >= SLOTS) begin
                        rsp.status = ST_FULL;
                    end else begin
                        if (id == '0) begin
                            id           = next_auto_id;
                            next_auto_id = next_auto_id + 1;
                        end else if (id >= next_auto_id) begin
                            next_auto_id = id + 1;
                        end
                        box_valid[slot]       = 1'b1;
                        box_store[slot].world = r.world_tag;
                        box_store[slot].id    = id;
                        box_store[slot].lo_x  = r.min_x;
                        box_store[slot].lo_y  = r.min_y;
                        box_store[slot].lo_z  = r.min_z;
                        box_store[slot].hi_x  = r.max_x;
                        box_store[slot].hi_y  = r.max_y;
                        box_store[slot].hi_z  = r.max_z;
                        rsp.result_id         = id;
                    end
                end
            end
            ACT_DESTROY: begin
                if (id == '0) begin
                    rsp.status = ST_ZEROID;
                end else begin
                    slot = find_box(r.world_tag, id);
                    if (slot < 0)
                        rsp.status = ST_NOTFOUND;
                    else
                        box_valid[slot] = 1'b0;
                end
            end
            ACT_LOCATE: begin
                rsp.status = ST_NOTFOUND;
                for (slot = 0; slot < SLOTS && rsp.status != ST_OK; slot++) begin
                    if (box_valid[slot] && box_store[slot].world == r.world_tag &&
                        $signed(r.point_x) >= $signed(box_store[slot].lo_x) &&
                        $signed(r.point_x) <= $signed(box_store[slot].hi_x) &&
                        $signed(r.point_y) >= $signed(box_store[slot].lo_y) &&
                        $signed(r.point_y) <= $signed(box_store[slot].hi_y) &&
                        $signed(r.point_z) >= $signed(box_store[slot].lo_z) &&
                        $signed(r.point_z) <= $signed(box_store[slot].hi_z)) begin
                        rsp.status    = ST_OK;
                        rsp.result_id = box_store[slot].id;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // results first, so a result and a new request on one edge are both handled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (box_valid[k])
                box_valid[k] = 1'b0;
            next_auto_id = 1;
            pending_rsp.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("result with no request outstanding", i_rsp.result_id, '0);
                end else begin
                    want = pending_rsp.pop_front();
                    o_checked++;
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 32'(i_rsp.status), 32'(want.status));
                    if (i_rsp.result_id !== want.result_id)
                        report_mismatch("result id", i_rsp.result_id, want.result_id);
                end
            end
            if (i_start && i_busy === 1'b0)
                pending_rsp.push_back(predict_table_op(i_req));
        end
        o_outstanding = pending_rsp.size();
    end

endmodule

FILE: test/tb_aabb_volume_table_locate.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the box table. Prediction and comparison live in
// the checker instantiated beside the block.
module tb_aabb_volume_table_locate;
    import avtl_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int MAX_GAP        = 40;
    localparam int MIXED_ITEMS    = 300;
    localparam int FILL_GUARD     = 210;
    localparam int TAIL_ITEMS     = 40;
    // one request scans every slot; a clearing pass follows reset
    localparam int DRAIN_CYCLES   = SLOTS + 100;
    localparam int WATCHDOG_LIMIT = 8000;

    // action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] ONE  = 64'sh0000_0001_0000_0000;
    localparam logic signed [COORD_W-1:0] MINV = 64'sh8000_0000_0000_0000;
    localparam logic signed [COORD_W-1:0] MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    int mismatches;
    int outstanding;
    int checked;

    // stimulus bookkeeping: requests in flight and boxes believed live
    t_req   in_flight [$];
    t_entry live_boxes [$];
    t_req   done_req;
    t_entry new_box;
    int     pool_idx;
    bit     removed;

    int n_sent    = 0;
    int n_create  = 0;
    int n_destroy = 0;
    int n_locate  = 0;
    int n_unused  = 0;
    int n_full    = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    aabb_volume_table_locate u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    aabb_table_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_done        (o_done),
        .i_rsp         (o_rsp),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // Track what the block reports so later requests can aim at live boxes:
    // destroy targets, duplicate ids and points inside known boxes. This only
    // steers stimulus; nothing here is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1 && in_flight.size() > 0) begin
                done_req = in_flight.pop_front();
                if (done_req.action == ACT_CREATE && o_rsp.status == ST_OK) begin
                    new_box.world = done_req.world_tag;
                    new_box.id    = o_rsp.result_id;
                    new_box.lo_x  = done_req.min_x;
                    new_box.lo_y  = done_req.min_y;
                    new_box.lo_z  = done_req.min_z;
                    new_box.hi_x  = done_req.max_x;
                    new_box.hi_y  = done_req.max_y;
                    new_box.hi_z  = done_req.max_z;
                    live_boxes.push_back(new_box);
                end else if (done_req.action == ACT_CREATE && o_rsp.status == ST_FULL) begin
                    n_full++;
                end else if (done_req.action == ACT_DESTROY && o_rsp.status == ST_OK) begin
                    removed = 1'b0;
                    for (pool_idx = 0; pool_idx < live_boxes.size() && !removed; pool_idx++) begin
                        if (live_boxes[pool_idx].world == done_req.world_tag &&
                            live_boxes[pool_idx].id == done_req.volume_id) begin
                            live_boxes.delete(pool_idx);
                            removed = 1'b1;
                        end
                    end
                end
            end
            if (start && busy === 1'b0) begin
                in_flight.push_back(i_req);
                case (i_req.action)
                    ACT_CREATE:  n_create++;
                    ACT_DESTROY: n_destroy++;
                    ACT_LOCATE:  n_locate++;
                    default:     n_unused++;
                endcase
            end
        end
    end

    // watchdog: cycles with no transfer in either direction
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // roughly +-4 units with every fraction bit live
    function automatic logic signed [63:0] small_coord();
        logic [63:0] v;
        v = rand64();
        return {{29{v[34]}}, v[34:0]};
    endfunction

    function automatic logic [WORLD_W-1:0] rand_world();
        if ($urandom_range(0, 99) < 80)
            return 4'($urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    // every field random, so fields a given action ignores still toggle
    function automatic t_req rand_bits();
        t_req r;
        r.action    = 2'($urandom());
        r.world_tag = 4'($urandom());
        r.volume_id = $urandom();
        r.min_x     = rand64();
        r.min_y     = rand64();
        r.min_z     = rand64();
        r.max_x     = rand64();
        r.max_y     = rand64();
        r.max_z     = rand64();
        r.point_x   = rand64();
        r.point_y   = rand64();
        r.point_z   = rand64();
        return r;
    endfunction

    function automatic t_req base_req(logic [1:0] act, logic [WORLD_W-1:0] world,
                                      logic [ID_W-1:0] id);
        t_req r;
        r           = rand_bits();
        r.action    = act;
        r.world_tag = world;
        r.volume_id = id;
        return r;
    endfunction

    function automatic t_req with_cube(t_req r, logic signed [63:0] lo, logic signed [63:0] hi);
        r.min_x = lo;
        r.min_y = lo;
        r.min_z = lo;
        r.max_x = hi;
        r.max_y = hi;
        r.max_z = hi;
        return r;
    endfunction

    function automatic t_req with_point(t_req r, logic signed [63:0] x, logic signed [63:0] y,
                                        logic signed [63:0] z);
        r.point_x = x;
        r.point_y = y;
        r.point_z = z;
        return r;
    endfunction

    // mostly small boxes, some inverted on one axis, a few left fully random
    function automatic t_req rand_box(t_req r);
        logic signed [63:0] lo [3];
        logic signed [63:0] hi [3];
        logic [63:0]        ext;
        int                 kind;
        int                 ax;
        kind = $urandom_range(0, 99);
        if (kind < 8)
            return r;
        for (ax = 0; ax < 3; ax++) begin
            lo[ax] = small_coord();
            ext    = {29'd0, 3'($urandom_range(0, 7)), $urandom()};
            hi[ax] = lo[ax] + ext;
        end
        if (kind < 16) begin
            ax     = $urandom_range(0, 2);
            hi[ax] = lo[ax] - 64'sd1 - $signed({32'd0, $urandom()});
        end
        r.min_x = lo[0];
        r.min_y = lo[1];
        r.min_z = lo[2];
        r.max_x = hi[0];
        r.max_y = hi[1];
        r.max_z = hi[2];
        return r;
    endfunction

    // somewhere from the lower corner up to the upper corner, both included
    function automatic logic signed [63:0] inside_coord(logic signed [63:0] lo,
                                                        logic signed [63:0] hi);
        logic [63:0] d;
        d = hi - lo;
        return lo + (d >> $urandom_range(0, 40));
    endfunction

    function automatic t_entry pick_box();
        return live_boxes[$urandom_range(0, live_boxes.size() - 1)];
    endfunction

    function automatic t_req rand_create();
        t_req   r;
        t_entry b;
        int     m;
        r           = rand_box(base_req(ACT_CREATE, rand_world(), '0));
        m           = $urandom_range(0, 99);
        if (m >= 50 && m < 70 && live_boxes.size() > 0) begin
            // reuse a live id: same world is a duplicate, another world is not
            b           = pick_box();
            r.volume_id = b.id;
            if ($urandom_range(0, 1) == 1)
                r.world_tag = b.world;
        end else if (m >= 70 && m < 90) begin
            r.volume_id = $urandom_range(1, 5000);
        end else if (m >= 90) begin
            r.volume_id = $urandom();
        end
        return r;
    endfunction

    function automatic t_req rand_destroy();
        t_req   r;
        t_entry b;
        int     m;
        r = base_req(ACT_DESTROY, rand_world(), $urandom());
        m = $urandom_range(0, 99);
        if (m < 72 && live_boxes.size() > 0) begin
            b           = pick_box();
            r.volume_id = b.id;
            if (m < 60)
                r.world_tag = b.world;
        end else if (m < 82) begin
            r.volume_id = '0;
        end
        return r;
    endfunction

    function automatic t_req rand_locate();
        t_req   r;
        t_entry b;
        int     m;
        r = base_req(ACT_LOCATE, 4'($urandom()), '0);
        m = $urandom_range(0, 99);
        if (m < 70 && live_boxes.size() > 0) begin
            b           = pick_box();
            r.world_tag = b.world;
            r.point_x   = inside_coord(b.lo_x, b.hi_x);
            r.point_y   = inside_coord(b.lo_y, b.hi_y);
            r.point_z   = inside_coord(b.lo_z, b.hi_z);
            // step just past one face
            if (m >= 55) begin
                case ($urandom_range(0, 2))
                    0:       r.point_x = $urandom_range(0, 1) ? b.hi_x + 1 : b.lo_x - 1;
                    1:       r.point_y = $urandom_range(0, 1) ? b.hi_y + 1 : b.lo_y - 1;
                    default: r.point_z = $urandom_range(0, 1) ? b.hi_z + 1 : b.lo_z - 1;
                endcase
            end
        end else if (m < 85) begin
            r = with_point(r, small_coord(), small_coord(), small_coord());
            r.world_tag = rand_world();
        end
        return r;
    endfunction

    function automatic t_req rand_mixed(int pc, int pd, int pl);
        int m;
        m = $urandom_range(0, 99);
        if (m < pc)
            return rand_create();
        if (m < pc + pd)
            return rand_destroy();
        if (m < pc + pd + pl)
            return rand_locate();
        return base_req(ACT_UNUSED, 4'($urandom()), $urandom());
    endfunction

    // idle phases of 40 transfers: none, idle 65 in 100, idle 32 in 100
    function automatic int idle_pct();
        case ((n_sent / 40) % 3)
            0:       return 0;
            1:       return 65;
            default: return 32;
        endcase
    endfunction

    // Present one request and hold it until the block takes it. start stays
    // high across back-to-back transfers; it drops only for a real gap, which
    // sometimes waits for the block to go idle first.
    task automatic send_req(input t_req r);
        int pct;
        int gap;
        pct = idle_pct();
        if (pct > 0 && $urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            if ($urandom_range(0, 1) == 1) begin
                while (busy) @(posedge i_clk);
            end
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(0, 99) < pct) begin
                @(posedge i_clk);
                gap++;
            end
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    initial begin
        t_req r;
        int   k;
        int   full_mark;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // empty table: locate miss, zero-id destroy, destroy miss
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), '0, '0, '0));
        send_req(base_req(ACT_DESTROY, 4'd0, '0));
        send_req(base_req(ACT_DESTROY, 4'd0, 32'd5));
        // two automatic ids on the same unit cube, then a duplicate
        send_req(with_cube(base_req(ACT_CREATE, 4'd0, '0), -ONE, ONE));
        send_req(with_cube(base_req(ACT_CREATE, 4'd0, '0), -ONE, ONE));
        send_req(with_cube(base_req(ACT_CREATE, 4'd0, 32'd1), -ONE, ONE));
        // same id in another world is fine
        send_req(with_cube(base_req(ACT_CREATE, 4'd15, 32'd1), -ONE, ONE));
        // large explicit id moves the counter; box spans the whole range
        send_req(with_cube(base_req(ACT_CREATE, 4'd3, 32'd100), MINV, MAXV));
        // inverted on y: contains nothing
        r = with_cube(base_req(ACT_CREATE, 4'd0, '0), 2 * ONE, 3 * ONE);
        r.min_y = 4 * ONE;
        send_req(r);
        // inclusive corners, one step outside, inside the inverted box
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), ONE, ONE, ONE));
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), -ONE, -ONE, -ONE));
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), ONE + 1, '0, '0));
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), 2 * ONE, 4 * ONE, 2 * ONE));
        send_req(with_point(base_req(ACT_LOCATE, 4'd3, '0), MINV, MINV, MINV));
        send_req(with_point(base_req(ACT_LOCATE, 4'd3, '0), MAXV, MAXV, MAXV));
        // destroy the first box; the second copy now answers
        send_req(base_req(ACT_DESTROY, 4'd0, 32'd1));
        send_req(with_point(base_req(ACT_LOCATE, 4'd0, '0), '0, '0, '0));
        send_req(base_req(ACT_DESTROY, 4'd0, 32'd1));
        // all-ones id wraps the counter to zero; next automatic create restarts at one
        send_req(with_cube(base_req(ACT_CREATE, 4'd2, 32'hFFFF_FFFF), -ONE, ONE));
        send_req(with_cube(base_req(ACT_CREATE, 4'd2, '0), -ONE, ONE));
        send_req(with_cube(base_req(ACT_CREATE, 4'd2, '0), -ONE, ONE));
        send_req(base_req(ACT_UNUSED, 4'($urandom()), $urandom()));
        send_req(base_req(ACT_DESTROY, 4'd2, 32'hFFFF_FFFF));
        send_req(with_point(base_req(ACT_LOCATE, 4'd15, '0), '0, '0, '0));

        // --- random, mixed traffic ---
        for (k = 0; k < MIXED_ITEMS; k++)
            send_req(rand_mixed(45, 20, 30));

        // --- create-heavy burst; stops early if the block reports the table full ---
        full_mark = n_full;
        k = 0;
        while (n_full == full_mark && k < FILL_GUARD) begin
            r = rand_create();
            if ($urandom_range(0, 99) < 75)
                r.volume_id = '0;
            send_req(r);
            k++;
        end

        // after the burst: automatic id, duplicate of a live id, fresh explicit id
        r = rand_create();
        r.volume_id = '0;
        send_req(r);
        if (live_boxes.size() > 0) begin
            new_box     = pick_box();
            r           = rand_create();
            r.world_tag = new_box.world;
            r.volume_id = new_box.id;
            send_req(r);
        end
        r = rand_create();
        r.volume_id = $urandom();
        send_req(r);

        // churn on a crowded table: freed slots get reused lowest first
        for (k = 0; k < TAIL_ITEMS; k++)
            send_req(rand_mixed(40, 35, 20));
        start <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests taken: %0d create, %0d destroy, %0d locate, %0d unused",
                 n_create, n_destroy, n_locate, n_unused);
        $display("Results checked: %0d; creates refused for a full table: %0d; boxes live: %0d",
                 checked, n_full, live_boxes.size());
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/avtl_pkg.sv
rtl/avtl_store.sv
rtl/avtl_match.sv
rtl/avtl_seq.sv
rtl/aabb_volume_table_locate.sv
test/aabb_table_checker.sv
test/tb_aabb_volume_table_locate.sv
